// ===== hw/rtl/ocvt_pkg.sv =====
// Shared types and codes for the capacity-to-voltage table keeper.
package ocvt_pkg;

  // Operation codes carried in the input word's user bits
  localparam logic [1:0] OP_ADD_DEFAULT = 2'd0;
  localparam logic [1:0] OP_STAGE       = 2'd1;
  localparam logic [1:0] OP_COMMIT      = 2'd2;
  localparam logic [1:0] OP_LOOKUP      = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND    = 2'd1;
  localparam logic [1:0] ST_FULL         = 2'd2;
  localparam logic [1:0] ST_EMPTY_COMMIT = 2'd3;

  localparam int ENTRY_W = 24;

  // One table entry: voltage above capacity
  typedef struct packed {
    logic [15:0] volt;
    logic [7:0]  cap;
  } entry_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SLD   = 9'b000000010,
    S_SKEY  = 9'b000000100,
    S_SSCAN = 9'b000001000,
    S_SWR   = 9'b000010000,
    S_MONO  = 9'b000100000,
    S_LOOKA = 9'b001000000,
    S_LOOKF = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

endpackage

// ===== hw/rtl/ocvt_ram.sv =====
// Single-write, single-read synchronous table memory with registered read data.
module ocvt_ram #(
  parameter int W  = 24,
  parameter int D  = 128,
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ocv_table_sort_and_lookup_top.sv =====
// Top level: command sequencer around the staged, active and default table memories.
//
//  channel | dir | handshake            | payload
//  in      | in  | in_tvalid/in_tready  | tdata: capacity, voltage_in; tuser: op
//  out     | out | out_tvalid/out_tready| tdata: status, voltage_out; tuser: from_default
//
// Add and stage words, and an empty commit, go straight from idle to the final state.
// A lookup makes one table memory read per entry scanned, active table first.
// A commit makes a rank scan of the staging memory per entry,
// then one pass over the active memory to make voltages non-decreasing.
// Synchronous active-low reset clears counts and control; memory contents are left as is.
// A result waiting on out_tready holds the sequencer in its final state; a new input word
// is taken as soon as the sequencer is idle.
module ocv_table_sort_and_lookup_top
  import ocvt_pkg::*;
#(
  parameter int DYNAMIC_DEPTH = 128,
  parameter int DEFAULT_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] capacity, [23:8] voltage_in
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [1:0] status, [17:2] voltage_out, [23:18] zero
  output logic        out_tuser   // [0] from_default
);

  localparam int DAW = $clog2(DYNAMIC_DEPTH);
  localparam int DCW = $clog2(DYNAMIC_DEPTH + 1);
  localparam int FAW = (DEFAULT_DEPTH > 1) ? $clog2(DEFAULT_DEPTH) : 1;
  localparam int FCW = $clog2(DEFAULT_DEPTH + 1);
  localparam int CW  = (DCW > FCW) ? DCW : FCW;

  state_t state_r, state_nxt;

  logic [DCW-1:0] sc_r, sc_nxt;
  logic [DCW-1:0] ac_r, ac_nxt;
  logic [FCW-1:0] fc_r, fc_nxt;
  logic [DCW-1:0] i_r, i_nxt;
  logic [CW-1:0]  k_r, k_nxt;
  logic [CW-1:0]  kp_r, kp_nxt;
  logic           rv_r, rv_nxt;
  logic [DCW-1:0] rank_r, rank_nxt;
  logic [15:0]    vmax_r, vmax_nxt;
  entry_t         key_r, key_nxt;
  logic [7:0]     cap_r, cap_nxt;

  logic [1:0]     res_st_r, res_st_nxt;
  logic [15:0]    res_v_r, res_v_nxt;
  logic           res_d_r, res_d_nxt;

  logic           ov_r, ov_nxt;
  logic [1:0]     o_st_r, o_st_nxt;
  logic [15:0]    o_v_r, o_v_nxt;
  logic           o_d_r, o_d_nxt;

  // Memory ports
  logic           st_we, ac_we, fb_we;
  logic [DAW-1:0] st_waddr, st_raddr, ac_waddr, ac_raddr;
  logic [FAW-1:0] fb_waddr, fb_raddr;
  entry_t         st_wdata, ac_wdata, fb_wdata;
  logic [ENTRY_W-1:0] st_rdata, ac_rdata, fb_rdata;
  entry_t         st_rd, ac_rd, fb_rd;

  logic           in_fire;
  logic [1:0]     in_op;
  entry_t         in_ent;
  logic [15:0]    vnew;
  logic           before_key;

  assign st_rd = entry_t'(st_rdata);
  assign ac_rd = entry_t'(ac_rdata);
  assign fb_rd = entry_t'(fb_rdata);

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_op     = in_tuser;
  assign in_ent    = entry_t'(in_tdata);

  ocvt_ram #(.W(ENTRY_W), .D(DYNAMIC_DEPTH), .AW(DAW)) u_staged (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  ocvt_ram #(.W(ENTRY_W), .D(DYNAMIC_DEPTH), .AW(DAW)) u_active (
    .clk(clk), .we(ac_we), .waddr(ac_waddr), .wdata(ac_wdata),
    .raddr(ac_raddr), .rdata(ac_rdata)
  );

  ocvt_ram #(.W(ENTRY_W), .D(DEFAULT_DEPTH), .AW(FAW)) u_default (
    .clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
    .raddr(fb_raddr), .rdata(fb_rdata)
  );

  // Rank test: staged entry that sorts ahead of the key
  always_comb begin
    before_key = ($signed(st_rd.cap) < $signed(key_r.cap)) ||
                 ((st_rd.cap == key_r.cap) && (DCW'(kp_r) < i_r));
  end

  // Running maximum for the monotonic pass
  always_comb begin
    if (kp_r == '0 || ac_rd.volt > vmax_r) begin
      vnew = ac_rd.volt;
    end else begin
      vnew = vmax_r;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    sc_nxt     = sc_r;
    ac_nxt     = ac_r;
    fc_nxt     = fc_r;
    i_nxt      = i_r;
    k_nxt      = k_r;
    kp_nxt     = kp_r;
    rv_nxt     = rv_r;
    rank_nxt   = rank_r;
    vmax_nxt   = vmax_r;
    key_nxt    = key_r;
    cap_nxt    = cap_r;
    res_st_nxt = res_st_r;
    res_v_nxt  = res_v_r;
    res_d_nxt  = res_d_r;
    ov_nxt     = ov_r && !out_tready;
    o_st_nxt   = o_st_r;
    o_v_nxt    = o_v_r;
    o_d_nxt    = o_d_r;

    st_we    = 1'b0;
    st_waddr = sc_r[DAW-1:0];
    st_wdata = in_ent;
    st_raddr = i_r[DAW-1:0];
    ac_we    = 1'b0;
    ac_waddr = rank_r[DAW-1:0];
    ac_wdata = key_r;
    ac_raddr = k_r[DAW-1:0];
    fb_we    = 1'b0;
    fb_waddr = fc_r[FAW-1:0];
    fb_wdata = in_ent;
    fb_raddr = k_r[FAW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_st_nxt = ST_OK;
          res_v_nxt  = '0;
          res_d_nxt  = 1'b0;
          cap_nxt    = in_ent.cap;
          k_nxt      = '0;
          rv_nxt     = 1'b0;
          i_nxt      = '0;
          state_nxt  = S_DONE;
          case (in_op)
            OP_ADD_DEFAULT: begin
              if (fc_r >= FCW'(DEFAULT_DEPTH)) begin
                res_st_nxt = ST_FULL;
              end else begin
                fb_we  = 1'b1;
                fc_nxt = fc_r + 1'b1;
              end
            end
            OP_STAGE: begin
              if (sc_r >= DCW'(DYNAMIC_DEPTH)) begin
                res_st_nxt = ST_FULL;
              end else begin
                st_we  = 1'b1;
                sc_nxt = sc_r + 1'b1;
              end
            end
            OP_COMMIT: begin
              if (sc_r == '0) begin
                res_st_nxt = ST_EMPTY_COMMIT;
              end else begin
                state_nxt = S_SLD;
              end
            end
            default: begin
              state_nxt = S_LOOKA;
            end
          endcase
        end
      end

      // Fetch the entry to be placed
      S_SLD: begin
        st_raddr  = i_r[DAW-1:0];
        state_nxt = S_SKEY;
      end

      // Latch the key and start the rank scan
      S_SKEY: begin
        key_nxt   = st_rd;
        st_raddr  = '0;
        kp_nxt    = '0;
        k_nxt     = CW'(1);
        rank_nxt  = '0;
        state_nxt = S_SSCAN;
      end

      // Count staged entries that sort ahead of the key
      S_SSCAN: begin
        if (before_key) begin
          rank_nxt = rank_r + 1'b1;
        end
        st_raddr = k_r[DAW-1:0];
        if (k_r < CW'(sc_r)) begin
          kp_nxt = k_r;
          k_nxt  = k_r + 1'b1;
        end else begin
          state_nxt = S_SWR;
        end
      end

      // Place the key at its rank
      S_SWR: begin
        ac_we    = 1'b1;
        ac_waddr = rank_r[DAW-1:0];
        ac_wdata = key_r;
        i_nxt    = i_r + 1'b1;
        if (i_r + 1'b1 == sc_r) begin
          state_nxt = S_MONO;
          k_nxt     = '0;
          kp_nxt    = '0;
          rv_nxt    = 1'b0;
        end else begin
          state_nxt = S_SLD;
        end
      end

      // Raise each voltage to at least its predecessor's
      S_MONO: begin
        ac_raddr = k_r[DAW-1:0];
        ac_waddr = kp_r[DAW-1:0];
        ac_wdata = '{volt: vnew, cap: ac_rd.cap};
        if (rv_r) begin
          ac_we    = 1'b1;
          vmax_nxt = vnew;
        end
        if (k_r < CW'(sc_r)) begin
          kp_nxt = k_r;
          k_nxt  = k_r + 1'b1;
          rv_nxt = 1'b1;
        end else begin
          rv_nxt    = 1'b0;
          ac_nxt    = sc_r;
          sc_nxt    = '0;
          state_nxt = S_DONE;
        end
      end

      // Scan the active table
      S_LOOKA: begin
        ac_raddr = k_r[DAW-1:0];
        if (rv_r && ac_rd.cap == cap_r) begin
          res_v_nxt = ac_rd.volt;
          state_nxt = S_DONE;
        end else if (k_r < CW'(ac_r)) begin
          k_nxt  = k_r + 1'b1;
          rv_nxt = 1'b1;
        end else begin
          k_nxt     = '0;
          rv_nxt    = 1'b0;
          state_nxt = S_LOOKF;
        end
      end

      // Scan the default table
      S_LOOKF: begin
        fb_raddr = k_r[FAW-1:0];
        if (rv_r && fb_rd.cap == cap_r) begin
          res_v_nxt = fb_rd.volt;
          res_d_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (k_r < CW'(fc_r)) begin
          k_nxt  = k_r + 1'b1;
          rv_nxt = 1'b1;
        end else begin
          res_st_nxt = ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          o_st_nxt  = res_st_r;
          o_v_nxt   = res_v_r;
          o_d_nxt   = res_d_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sc_r    <= '0;
      ac_r    <= '0;
      fc_r    <= '0;
      ov_r    <= 1'b0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sc_r    <= sc_nxt;
      ac_r    <= ac_nxt;
      fc_r    <= fc_nxt;
      ov_r    <= ov_nxt;
      rv_r    <= rv_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    k_r      <= k_nxt;
    kp_r     <= kp_nxt;
    rank_r   <= rank_nxt;
    vmax_r   <= vmax_nxt;
    key_r    <= key_nxt;
    cap_r    <= cap_nxt;
    res_st_r <= res_st_nxt;
    res_v_r  <= res_v_nxt;
    res_d_r  <= res_d_nxt;
    o_st_r   <= o_st_nxt;
    o_v_r    <= o_v_nxt;
    o_d_r    <= o_d_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, o_v_r, o_st_r};
  assign out_tuser  = o_d_r;

  // Counts never exceed their table depth
  assert property (@(posedge clk) disable iff (!rst_n)
    (sc_r <= DCW'(DYNAMIC_DEPTH)) && (fc_r <= FCW'(DEFAULT_DEPTH)))
    else $error("table count beyond depth");

  // A placed entry lands inside the staged range
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWR) |-> (rank_r < sc_r))
    else $error("sort rank out of range");

  // A finished result reaches the output register when it is free
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!ov_r || out_tready)) |=> (ov_r && state_r == S_IDLE))
    else $error("result not delivered");

  // Input is only taken while idle, and taking it moves the sequencer out of idle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("sequencer did not leave idle");

endmodule
